// ===== hw/rtl/cbo_pkg.sv =====
// Shared constants, the sideband struct and the CORDIC step-angle table for the bearing core.
`default_nettype none
package cbo_pkg;

	localparam int OFFSET_WIDTH_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	localparam int CORDIC_STEPS = 48;
	localparam int TURN_BITS    = 48;
	localparam int XY_W         = 63;	// holds 2^60 grown by the CORDIC gain
	localparam int Z_W          = 50;	// signed angle accumulator, half-turn units
	localparam int T_W          = 50;	// folded angle, 0 .. 2^49
	localparam int A_W          = 47;	// step angle and clamped arctangent, 0 .. 2^46
	localparam int PROD_W       = 58;	// folded angle times 180 plus rounding

	localparam logic [A_W-1:0] EIGHTH_TURN = A_W'(64'd1 << 46);

	// quarter-turn count added in front of the arctangent
	localparam logic [2:0] QUAD_N    = 3'd0;
	localparam logic [2:0] QUAD_E    = 3'd1;
	localparam logic [2:0] QUAD_S    = 3'd2;
	localparam logic [2:0] QUAD_W    = 3'd3;
	localparam logic [2:0] QUAD_FULL = 3'd4;

	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

	localparam int SERIES_POW2 = 0;
	localparam int SERIES_5    = 1;
	localparam int SERIES_239  = 2;

	typedef struct packed {
		logic [2:0] base;	// quarter turns in front of the arctangent
		logic       neg;	// subtract the arctangent from the base
		logic       zero_z;	// axis or zero offset: no arctangent
		logic       eighth;	// equal magnitudes: arctangent is exactly 45 degrees
	} oct_t;

	// arctangent of 1/n in radians Q60 by its power series, truncating each division
	function automatic logic [63:0] atan_series(input int sel, input int sh);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		logic [64:0] r;
		logic [64:0] d;
		int k;
		int b;
		begin
			case (sel)
				SERIES_5:   term = ONE_Q60 / 5;
				SERIES_239: term = ONE_Q60 / 239;
				default:    term = ONE_Q60 >> sh;
			endcase
			sum = 64'd0;
			for (k = 0; k < 64; k++) begin
				if (term != 64'd0) begin
					d = 65'(2 * k + 1);
					r = 65'd0;
					q = 64'd0;
					for (b = 63; b >= 0; b--) begin
						r = {r[63:0], term[b]};
						if (r >= d) begin
							r = r - d;
							q[b] = 1'b1;
						end
					end
					if ((k % 2) == 1) sum = sum - q;
					else sum = sum + q;
					case (sel)
						SERIES_5:   term = term / 5 / 5;
						SERIES_239: term = term / 239 / 239;
						default:    term = (2 * sh >= 64) ? 64'd0 : (term >> (2 * sh));
					endcase
				end
			end
			return sum;
		end
	endfunction

	// radians Q60 (a < p) to 2^-48 half-turn units, rounded to nearest
	function automatic logic [63:0] to_half_turns(input logic [63:0] a, input logic [63:0] p);
		logic [63:0] r;
		logic [63:0] q;
		int b;
		begin
			r = a;
			q = 64'd0;
			for (b = 0; b < TURN_BITS; b++) begin
				r = r << 1;
				q = q << 1;
				if (r >= p) begin
					r = r - p;
					q[0] = 1'b1;
				end
			end
			if ((r << 1) >= p) q = q + 64'd1;
			return q;
		end
	endfunction

	function automatic logic [A_W-1:0] step_angle(input int step);
		logic [63:0] pi_q60;
		logic [63:0] ang;
		begin
			pi_q60 = 64'd16 * atan_series(SERIES_5, 0) - 64'd4 * atan_series(SERIES_239, 0);
			if (step == 0) ang = 64'd1 << 46;
			else ang = to_half_turns(atan_series(SERIES_POW2, step), pi_q60);
			return ang[A_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cbo_prep.sv =====
// Input stage: magnitudes, octant decode and CORDIC start vector.
`default_nettype none
module cbo_prep #(
	parameter int OFFSET_WIDTH = cbo_pkg::OFFSET_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_vld,
	input  wire logic signed [OFFSET_WIDTH-1:0]    offset_east,
	input  wire logic signed [OFFSET_WIDTH-1:0]    offset_north,
	output logic                                   vld_s1,
	output logic signed [cbo_pkg::XY_W-1:0]        x_s1,
	output logic signed [cbo_pkg::XY_W-1:0]        y_s1,
	output cbo_pkg::oct_t                          oct_s1
);

	localparam int SHIFT = 61 - OFFSET_WIDTH;
	localparam int XY_W  = cbo_pkg::XY_W;

	logic [OFFSET_WIDTH-1:0] ax, ay, small_mag, large_mag;
	logic                    ex_neg, ny_neg, ex_zero, ny_zero;
	cbo_pkg::oct_t           oct;

	always_comb begin
		ex_neg  = offset_east[OFFSET_WIDTH-1];
		ny_neg  = offset_north[OFFSET_WIDTH-1];
		ex_zero = (offset_east == '0);
		ny_zero = (offset_north == '0);
		ax = ex_neg ? OFFSET_WIDTH'(-offset_east) : OFFSET_WIDTH'(offset_east);
		ay = ny_neg ? OFFSET_WIDTH'(-offset_north) : OFFSET_WIDTH'(offset_north);

		oct.base   = cbo_pkg::QUAD_N;
		oct.neg    = 1'b0;
		oct.zero_z = 1'b1;
		oct.eighth = 1'b0;
		small_mag  = ax;
		large_mag  = ay;

		if (ex_zero && ny_zero) begin
			oct.base = cbo_pkg::QUAD_N;
		end else if (ex_zero) begin
			oct.base = ny_neg ? cbo_pkg::QUAD_S : cbo_pkg::QUAD_N;
		end else if (ny_zero) begin
			oct.base = ex_neg ? cbo_pkg::QUAD_W : cbo_pkg::QUAD_E;
		end else begin
			oct.zero_z = 1'b0;
			oct.eighth = (ax == ay);
			if (!ex_neg && !ny_neg) begin
				if (ay > ax) begin
					oct.base = cbo_pkg::QUAD_N;
				end else begin
					oct.base = cbo_pkg::QUAD_E;
					oct.neg  = 1'b1;
					small_mag = ay;
					large_mag = ax;
				end
			end else if (!ex_neg) begin
				if (ax > ay) begin
					oct.base = cbo_pkg::QUAD_E;
					small_mag = ay;
					large_mag = ax;
				end else begin
					oct.base = cbo_pkg::QUAD_S;
					oct.neg  = 1'b1;
				end
			end else if (ny_neg) begin
				if (ax < ay) begin
					oct.base = cbo_pkg::QUAD_S;
				end else begin
					oct.base = cbo_pkg::QUAD_W;
					oct.neg  = 1'b1;
					small_mag = ay;
					large_mag = ax;
				end
			end else begin
				if (ax > ay) begin
					oct.base = cbo_pkg::QUAD_W;
					small_mag = ay;
					large_mag = ax;
				end else begin
					oct.base = cbo_pkg::QUAD_FULL;
					oct.neg  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= $signed(XY_W'(large_mag) << SHIFT);
			y_s1   <= $signed(XY_W'(small_mag) << SHIFT);
			oct_s1 <= oct;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cbo_cell.sv =====
// One CORDIC vectoring step with its pipeline register.
`default_nettype none
module cbo_cell #(
	parameter int STEP = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_vld,
	input  wire logic signed [cbo_pkg::XY_W-1:0]   x_in,
	input  wire logic signed [cbo_pkg::XY_W-1:0]   y_in,
	input  wire logic signed [cbo_pkg::Z_W-1:0]    z_in,
	input  wire cbo_pkg::oct_t                     oct_in,
	output logic                                   vld_s1,
	output logic signed [cbo_pkg::XY_W-1:0]        x_s1,
	output logic signed [cbo_pkg::XY_W-1:0]        y_s1,
	output logic signed [cbo_pkg::Z_W-1:0]         z_s1,
	output cbo_pkg::oct_t                          oct_s1
);

	localparam int XY_W = cbo_pkg::XY_W;
	localparam int Z_W  = cbo_pkg::Z_W;
	localparam logic [cbo_pkg::A_W-1:0] ANGLE = cbo_pkg::step_angle(STEP);
	localparam logic signed [Z_W-1:0]   ANGLE_Z = $signed(Z_W'(ANGLE));
	localparam logic [XY_W-1:0]         LOW_MASK = (XY_W'(1) << STEP) - XY_W'(1);

	logic signed [XY_W-1:0] x_sh, y_sh, x_nx, y_nx;
	logic signed [Z_W-1:0]  z_nx;
	logic                   cx, cy;

	// shifts round toward zero: bump a negative value that lost nonzero bits
	always_comb begin
		x_sh = x_in >>> STEP;
		y_sh = y_in >>> STEP;
		cx   = x_in[XY_W-1] & (|(x_in & LOW_MASK));
		cy   = y_in[XY_W-1] & (|(y_in & LOW_MASK));
		if (!y_in[XY_W-1]) begin
			x_nx = x_in + y_sh + $signed(XY_W'(cy));
			y_nx = y_in - x_sh - $signed(XY_W'(cx));
			z_nx = z_in + ANGLE_Z;
		end else begin
			x_nx = x_in - y_sh - $signed(XY_W'(cy));
			y_nx = y_in + x_sh + $signed(XY_W'(cx));
			z_nx = z_in - ANGLE_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_nx;
			y_s1   <= y_nx;
			z_s1   <= z_nx;
			oct_s1 <= oct_in;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cbo_post.sv =====
// Clamp and fold the arctangent into its octant, then scale to rounded degrees.
`default_nettype none
module cbo_post #(
	parameter int ANGLE_FRAC_BITS = cbo_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_vld,
	input  wire logic signed [cbo_pkg::Z_W-1:0]    z_in,
	input  wire cbo_pkg::oct_t                     oct_in,
	output logic                                   vld_s2,
	output logic [9+ANGLE_FRAC_BITS-1:0]           bearing
);

	localparam int Z_W    = cbo_pkg::Z_W;
	localparam int T_W    = cbo_pkg::T_W;
	localparam int A_W    = cbo_pkg::A_W;
	localparam int PROD_W = cbo_pkg::PROD_W;
	localparam int BEAR_W = 9 + ANGLE_FRAC_BITS;
	localparam int SHIFT_OUT = 48 - ANGLE_FRAC_BITS;
	localparam logic [PROD_W-1:0] ROUND = PROD_W'(64'd1 << (47 - ANGLE_FRAC_BITS));
	localparam logic [BEAR_W-1:0] FULL  = BEAR_W'(360 << ANGLE_FRAC_BITS);
	localparam logic signed [Z_W-1:0] EIGHTH_Z = $signed(Z_W'(cbo_pkg::EIGHTH_TURN));

	logic [A_W-1:0]    z_clamp, z_fold;
	logic [T_W-1:0]    base_t, t_nx;
	logic [PROD_W-1:0] prod;
	logic              vld_s1;
	logic [T_W-1:0]    t_s1;
	logic [BEAR_W-1:0] res_s2;

	always_comb begin
		if (z_in[Z_W-1]) z_clamp = '0;
		else if (z_in > EIGHTH_Z) z_clamp = cbo_pkg::EIGHTH_TURN;
		else z_clamp = z_in[A_W-1:0];

		if (oct_in.zero_z) z_fold = '0;
		else if (oct_in.eighth) z_fold = cbo_pkg::EIGHTH_TURN;
		else z_fold = z_clamp;

		base_t = {oct_in.base, {(T_W-3){1'b0}}};
		t_nx   = oct_in.neg ? base_t - T_W'(z_fold) : base_t + T_W'(z_fold);
	end

	// degrees = half-turns * 180, round half up into the output LSB
	assign prod = PROD_W'(t_s1) * PROD_W'(180) + ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_nx;
			res_s2 <= prod[SHIFT_OUT +: BEAR_W];
		end
	end

	// a value that rounded up to a full turn wraps to north
	assign bearing = (res_s2 >= FULL) ? res_s2 - FULL : res_s2;

endmodule
`default_nettype wire

// ===== hw/rtl/compass_bearing_from_offset_core.sv =====
// Pipeline: 1 input stage, 48 CORDIC cells, 2 fold/scale stages and 1 output register
// lie between input accept and the result on the master side.
// Throughput: one item per cycle while the skid entry is empty; every CORDIC cell is its own pipeline stage.
// An output register plus one skid entry lets the input keep flowing while the master side
// stalls, until a result lands in the skid entry. Reset (arst_n low) clears all valid flags; data is not reset.
`default_nettype none
module compass_bearing_from_offset_core #(
	parameter int OFFSET_WIDTH    = cbo_pkg::OFFSET_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = cbo_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        s_axis_tvalid,
	output logic                                             s_axis_tready,
	// [OFFSET_WIDTH-1:0] offset_east, [2*OFFSET_WIDTH-1:OFFSET_WIDTH] offset_north
	input  wire logic [((2*OFFSET_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
	output logic                                             m_axis_tvalid,
	input  wire logic                                        m_axis_tready,
	// [9+ANGLE_FRAC_BITS-1:0] bearing_deg, zeros above
	output logic [((9+ANGLE_FRAC_BITS+7)/8)*8-1:0]           m_axis_tdata
);

	localparam int STEPS  = cbo_pkg::CORDIC_STEPS;
	localparam int XY_W   = cbo_pkg::XY_W;
	localparam int Z_W    = cbo_pkg::Z_W;
	localparam int BEAR_W = 9 + ANGLE_FRAC_BITS;
	localparam int OUT_TW = ((9 + ANGLE_FRAC_BITS + 7) / 8) * 8;

	// Whole pipeline advances together; it stops only while the skid entry is occupied.
	logic en;
	logic skid_vld_q, out_vld_q;
	logic [BEAR_W-1:0] skid_d_q, out_d_q;

	assign en = ~skid_vld_q;
	assign s_axis_tready = en;

	// Chain of cells: index 0 is the input stage, index k the output of CORDIC step k-1.
	logic                   vld_c [STEPS+1];
	logic signed [XY_W-1:0] x_c   [STEPS+1];
	logic signed [XY_W-1:0] y_c   [STEPS+1];
	logic signed [Z_W-1:0]  z_c   [STEPS+1];
	cbo_pkg::oct_t          oct_c [STEPS+1];

	cbo_prep #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_vld       (s_axis_tvalid),
		.offset_east  ($signed(s_axis_tdata[OFFSET_WIDTH-1:0])),
		.offset_north ($signed(s_axis_tdata[2*OFFSET_WIDTH-1:OFFSET_WIDTH])),
		.vld_s1       (vld_c[0]),
		.x_s1         (x_c[0]),
		.y_s1         (y_c[0]),
		.oct_s1       (oct_c[0])
	);

	// the angle accumulator starts from zero
	assign z_c[0] = '0;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		cbo_cell #(
			.STEP(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (vld_c[i]),
			.x_in   (x_c[i]),
			.y_in   (y_c[i]),
			.z_in   (z_c[i]),
			.oct_in (oct_c[i]),
			.vld_s1 (vld_c[i+1]),
			.x_s1   (x_c[i+1]),
			.y_s1   (y_c[i+1]),
			.z_s1   (z_c[i+1]),
			.oct_s1 (oct_c[i+1])
		);
	end

	logic              post_vld;
	logic [BEAR_W-1:0] post_bearing;

	cbo_post #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_c[STEPS]),
		.z_in    (z_c[STEPS]),
		.oct_in  (oct_c[STEPS]),
		.vld_s2  (post_vld),
		.bearing (post_bearing)
	);

	// Output register with one skid entry behind it.
	logic take, arrive;

	assign take   = out_vld_q & m_axis_tready;
	assign arrive = en & post_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			// pipeline is held; drain the skid entry into the output register
			if (take) skid_vld_q <= 1'b0;
		end else if (arrive) begin
			if (out_vld_q && !take) skid_vld_q <= 1'b1;
			else out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) out_d_q <= skid_d_q;
		end else if (arrive) begin
			if (out_vld_q && !take) skid_d_q <= post_bearing;
			else out_d_q <= post_bearing;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TW'(out_d_q);

endmodule
`default_nettype wire

// ===== tb/tb_compass_bearing_from_offset_core.sv =====
// Self-checking testbench for the compass bearing core: directed corners, then random traffic.
module tb_compass_bearing_from_offset_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OW    = cbo_pkg::OFFSET_WIDTH_DEF;
	localparam int FB    = cbo_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int BW    = 9 + FB;
	localparam int IN_W  = ((2 * OW + 7) / 8) * 8;
	localparam int OUT_W = ((BW + 7) / 8) * 8;

	// angle units are 2^-48 half-turn: 90 degrees is 2^47
	localparam int              ROT_STEPS  = 48;
	localparam int              MAG_SHIFT  = 61 - OW;
	localparam longint unsigned ONE_Q60    = 64'd1 << 60;
	localparam longint unsigned EIGHTH     = 64'd1 << 46;
	localparam longint unsigned DEG90      = 64'd1 << 47;
	localparam longint unsigned DEG360     = 64'd1 << 49;
	localparam longint unsigned ROUND_HALF = 64'd1 << (47 - FB);
	localparam longint unsigned FULL_TURN  = 64'd360 << FB;
	localparam int              DRAIN_CYCLES = 80;	// pipeline is 52 deep

	typedef struct {
		logic signed [OW-1:0] east;
		logic signed [OW-1:0] north;
		logic [BW-1:0]        bearing;
	} bearing_exp_t;

	logic             clk;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata  = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	bearing_exp_t    bearing_q[$];
	longint unsigned step_turns[ROT_STEPS];
	int              mismatch_count = 0;
	int              idle_pct = 0;
	int              stall_pct = 0;

	compass_bearing_from_offset_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// arctangent of 1/n in radians Q60, power series with truncating division
	function automatic longint unsigned atan_inv_q60(input longint unsigned n);
		longint unsigned term;
		longint unsigned sum;
		longint unsigned q;
		longint unsigned k;
		term = ONE_Q60 / n;
		sum = 0;
		k = 0;
		while (term != 0) begin
			q = term / (2 * k + 1);
			if (k % 2 == 1) sum = sum - q;
			else sum = sum + q;
			term = term / n / n;
			k++;
		end
		return sum;
	endfunction

	// build the per-step rotation angles in half-turn units
	initial begin : step_table_fill
		longint unsigned pi_q60;
		longint unsigned rem;
		longint unsigned quo;
		int i;
		int b;
		pi_q60 = 16 * atan_inv_q60(5) - 4 * atan_inv_q60(239);
		step_turns[0] = EIGHTH;
		for (i = 1; i < ROT_STEPS; i++) begin
			rem = atan_inv_q60(64'd1 << i);
			quo = 0;
			for (b = 0; b < 48; b++) begin
				rem = rem << 1;
				quo = quo << 1;
				if (rem >= pi_q60) begin
					rem = rem - pi_q60;
					quo = quo | 64'd1;
				end
			end
			if (2 * rem >= pi_q60) quo++;
			step_turns[i] = quo;
		end
	end

	// arithmetic right shift that rounds toward zero
	function automatic longint shift_to_zero(input longint v, input int s);
		return (v < 0) ? -((-v) >>> s) : (v >>> s);
	endfunction

	// atan(lo_mag / hi_mag) by vectoring rotations, 0 < lo_mag <= hi_mag
	function automatic longint unsigned atan_lo_over_hi(input longint unsigned lo_mag,
			input longint unsigned hi_mag);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		int i;
		if (lo_mag == hi_mag) return EIGHTH;
		x = longint'(hi_mag << MAG_SHIFT);
		y = longint'(lo_mag << MAG_SHIFT);
		z = 0;
		for (i = 0; i < ROT_STEPS; i++) begin
			dx = shift_to_zero(y, i);
			dy = shift_to_zero(x, i);
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(step_turns[i]);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(step_turns[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(EIGHTH)) z = longint'(EIGHTH);
		return $unsigned(z);
	endfunction

	// fold the arctangent into its octant, scale to degrees and round
	function automatic logic [BW-1:0] predict_bearing(input logic signed [OW-1:0] east,
			input logic signed [OW-1:0] north);
		longint ex;
		longint ny;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned t;
		longint unsigned res;
		ex = east;
		ny = north;
		ax = (ex < 0) ? -ex : ex;
		ay = (ny < 0) ? -ny : ny;
		if (ex == 0 && ny == 0) t = 0;
		else if (ex == 0) t = (ny > 0) ? 64'd0 : 2 * DEG90;
		else if (ny == 0) t = (ex < 0) ? 3 * DEG90 : DEG90;
		else if (ex > 0 && ny > 0)
			t = (ay > ax) ? atan_lo_over_hi(ax, ay) : DEG90 - atan_lo_over_hi(ay, ax);
		else if (ex > 0)
			t = (ax > ay) ? DEG90 + atan_lo_over_hi(ay, ax)
				: 2 * DEG90 - atan_lo_over_hi(ax, ay);
		else if (ny < 0)
			t = (ax < ay) ? 2 * DEG90 + atan_lo_over_hi(ax, ay)
				: 3 * DEG90 - atan_lo_over_hi(ay, ax);
		else
			t = (ax > ay) ? 3 * DEG90 + atan_lo_over_hi(ay, ax)
				: DEG360 - atan_lo_over_hi(ax, ay);
		res = (t * 180 + ROUND_HALF) >> (48 - FB);
		// a bearing that rounds up to a full turn wraps to north
		if (res >= FULL_TURN) res = res - FULL_TURN;
		return res[BW-1:0];
	endfunction

	// present one offset pair, hold it until accepted, queue its bearing
	task automatic send_offsets(input logic signed [OW-1:0] east,
			input logic signed [OW-1:0] north);
		int gap;
		bearing_exp_t want;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= IN_W'({north, east});
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		want.east    = east;
		want.north   = north;
		want.bearing = predict_bearing(east, north);
		bearing_q.insert(bearing_q.size(), want);
	endtask

	// drive the receiver's ready and compare each result with the oldest bearing
	always @(posedge clk) begin
		bearing_exp_t want;
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (bearing_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual bearing %0d",
					$time, m_axis_tdata[BW-1:0]);
			end else begin
				want = bearing_q.pop_front();
				if (m_axis_tdata[BW-1:0] !== want.bearing) begin
					mismatch_count++;
					$display("%0t: east %0d north %0d: expected bearing %0d, actual %0d",
						$time, want.east, want.north, want.bearing, m_axis_tdata[BW-1:0]);
				end
			end
		end
	end

	// zero offset and the four axes, including the most negative values
	task automatic test_zero_and_axes();
		send_offsets(0, 0);
		send_offsets(0, 1);
		send_offsets(0, -1);
		send_offsets(1, 0);
		send_offsets(-1, 0);
		send_offsets(-32768, 0);
		send_offsets(0, -32768);
	endtask

	// field extremes and equal magnitudes, where the angle is exactly 45 degrees
	task automatic test_extremes_and_diagonals();
		send_offsets(32767, 32767);
		send_offsets(-32768, -32768);
		send_offsets(32767, -32768);
		send_offsets(-32768, 32767);
		send_offsets(5, -5);
		send_offsets(-7, 7);
		send_offsets(1, 32767);
		send_offsets(32767, 1);
		send_offsets(-32768, -1);
		send_offsets(1, -32768);
	endtask

	// just west of north: both round up to a full turn and wrap
	task automatic test_north_wrap();
		send_offsets(-1, 32767);
		send_offsets(-1, 32000);
	endtask

	// one point in each octant
	task automatic test_octants();
		send_offsets(3, 5);
		send_offsets(5, 3);
		send_offsets(5, -3);
		send_offsets(3, -5);
		send_offsets(-3, -5);
		send_offsets(-5, -3);
		send_offsets(-5, 3);
		send_offsets(-3, 5);
	endtask

	// random offset pairs under four patterns of input idling and output stalls
	task automatic test_random_traffic(input int per_phase);
		int phase;
		int n;
		int m;
		logic signed [OW-1:0] e;
		logic signed [OW-1:0] nv;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 45; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 45; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			for (n = 0; n < per_phase; n++) begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						e  = OW'($urandom);
						nv = OW'($urandom);
					end
					4, 5: begin
						e  = OW'($urandom_range(32) - 16);
						nv = OW'($urandom_range(32) - 16);
					end
					6: begin
						// on or next to an axis
						e  = OW'($urandom_range(2) - 1);
						nv = OW'($urandom);
						if ($urandom_range(1)) begin
							nv = e;
							e  = OW'($urandom);
						end
					end
					7: begin
						// equal magnitudes with random signs
						m  = $urandom_range(1, 32768);
						e  = OW'($urandom_range(1) ? -m : m);
						nv = OW'($urandom_range(1) ? -m : m);
					end
					8: begin
						// close to north from either side, around the wrap
						e  = OW'($urandom_range(6) - 3);
						nv = OW'($urandom_range(32767, 16384));
					end
					default: begin
						e  = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
						nv = $urandom_range(1) ? OW'($urandom) : -e;
					end
				endcase
				send_offsets(e, nv);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_and_axes();
		test_extremes_and_diagonals();
		test_north_wrap();
		test_octants();
		test_random_traffic(325);

		s_axis_tvalid <= 1'b0;
		stall_pct = 20;
		while (bearing_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
